>>> rtl/rpip_pkg.sv
package rpip_pkg;

    // Command codes carried in the operation field.
    localparam logic [2:0] OP_HOME      = 3'd0;
    localparam logic [2:0] OP_GOTO_FWD  = 3'd1;
    localparam logic [2:0] OP_ADVANCE   = 3'd2;
    localparam logic [2:0] OP_GOTO_BWD  = 3'd3;
    localparam logic [2:0] OP_BACK_UP   = 3'd4;

    // Speed-curve codes and the cup-distance limits that select them.
    localparam logic [2:0] CURVE_DEBUG  = 3'd6;
    localparam logic [8:0] LIM_CURVE0   = 9'd1;
    localparam logic [8:0] LIM_CURVE1   = 9'd9;
    localparam logic [8:0] LIM_CURVE2   = 9'd13;
    localparam logic [8:0] LIM_CURVE3   = 9'd40;
    localparam logic [8:0] LIM_CURVE4   = 9'd59;
    localparam logic [8:0] LIM_CURVE5   = 9'd120;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_STEPS_PER_CUP = 2'd0;
    localparam logic [1:0] REG_MAX_CUP       = 2'd1;
    localparam logic [1:0] REG_HOME_CUP      = 2'd2;

    localparam logic signed [15:0] RST_STEPS_PER_CUP = 16'sd0;
    localparam logic [6:0]         RST_MAX_CUP       = 7'd120;
    localparam logic [6:0]         RST_HOME_CUP      = 7'd1;

    typedef struct packed {
        logic signed [15:0] steps_per_cup;
        logic [6:0]         max_cup;
        logic [6:0]         home_cup;
    } t_cfg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] cup_arg;
        logic       motion_ok;
    } t_cmd;

    typedef struct packed {
        logic signed [23:0] step_count;
        logic [2:0]         curve_code;
        logic [6:0]         next_cup;
        logic               update;
        logic               failed;
    } t_plan;

    // Curve selection from a signed cup distance; its magnitude is what counts.
    function automatic logic [2:0] pick_curve(input logic signed [9:0] cups,
                                              input logic              spc_zero);
        logic [9:0] mag;
        logic [2:0] code;
        mag = cups[9] ? 10'(-cups) : 10'(cups);
        if (spc_zero || mag[9]) begin
            code = CURVE_DEBUG;
        end else if (mag[8:0] <= LIM_CURVE0) begin
            code = 3'd0;
        end else if (mag[8:0] <= LIM_CURVE1) begin
            code = 3'd1;
        end else if (mag[8:0] <= LIM_CURVE2) begin
            code = 3'd2;
        end else if (mag[8:0] <= LIM_CURVE3) begin
            code = 3'd3;
        end else if (mag[8:0] <= LIM_CURVE4) begin
            code = 3'd4;
        end else if (mag[8:0] <= LIM_CURVE5) begin
            code = 3'd5;
        end else begin
            code = CURVE_DEBUG;
        end
        return code;
    endfunction

endpackage

>>> rtl/rpip_if.sv
interface rpip_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] cup_arg;
    logic       motion_ok;

    modport source (output valid, output operation, output cup_arg, output motion_ok,
                    input ready);
    modport sink (input valid, input operation, input cup_arg, input motion_ok,
                  output ready);
endinterface

interface rpip_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] step_count;
    logic [2:0]         curve_code;
    logic [6:0]         cup_index;
    logic               failed;

    modport source (output valid, output step_count, output curve_code,
                    output cup_index, output failed, input ready);
    modport sink (input valid, input step_count, input curve_code,
                  input cup_index, input failed, output ready);
endinterface

>>> rtl/rpip_cfg_regs.sv
module rpip_cfg_regs
    import rpip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_cup <= RST_STEPS_PER_CUP;
            r_cfg.max_cup       <= RST_MAX_CUP;
            r_cfg.home_cup      <= RST_HOME_CUP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_STEPS_PER_CUP: r_cfg.steps_per_cup <= pwdata[15:0];
                REG_MAX_CUP:       r_cfg.max_cup       <= pwdata[6:0];
                REG_HOME_CUP:      r_cfg.home_cup      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEPS_PER_CUP: prdata = {16'd0, r_cfg.steps_per_cup};
            REG_MAX_CUP:       prdata = {25'd0, r_cfg.max_cup};
            REG_HOME_CUP:      prdata = {25'd0, r_cfg.home_cup};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/rpip_plan.sv
module rpip_plan
    import rpip_pkg::*;
(
    input  t_cmd       i_cmd,
    input  logic [6:0] i_cur,
    input  t_cfg       i_cfg,
    output t_plan      o_plan
);

    logic [6:0]         arg_clamped;
    logic signed [9:0]  a_s;
    logic signed [9:0]  cur_s;
    logic signed [9:0]  mx_s;
    logic signed [9:0]  d_fwd;
    logic signed [9:0]  span;
    logic signed [9:0]  nxt;
    logic signed [25:0] prod;
    logic               negate;
    logic               known;
    logic               spc_zero;

    assign arg_clamped = (i_cmd.cup_arg > {1'b0, i_cfg.max_cup}) ? i_cfg.max_cup
                                                                  : i_cmd.cup_arg[6:0];
    assign a_s      = $signed({3'b000, arg_clamped});
    assign cur_s    = $signed({3'b000, i_cur});
    assign mx_s     = $signed({3'b000, i_cfg.max_cup});
    assign spc_zero = (i_cfg.steps_per_cup == 16'sd0);

    // Forward distance around the ring to the target cup.
    always_comb begin
        if (a_s > cur_s) begin
            d_fwd = a_s - cur_s;
        end else if (a_s < cur_s) begin
            d_fwd = mx_s - cur_s + a_s;
        end else begin
            d_fwd = 10'sd0;
        end
    end

    always_comb begin
        span   = 10'sd0;
        nxt    = cur_s;
        negate = 1'b0;
        known  = 1'b1;
        case (i_cmd.operation)
            OP_HOME: begin
                nxt = $signed({3'b000, i_cfg.home_cup});
            end
            OP_GOTO_FWD: begin
                span = d_fwd;
                nxt  = a_s;
            end
            OP_GOTO_BWD: begin
                span   = (d_fwd != 10'sd0) ? (mx_s - d_fwd) : 10'sd0;
                nxt    = a_s;
                negate = 1'b1;
            end
            OP_ADVANCE: begin
                span = a_s;
                nxt  = ((cur_s + a_s) > mx_s) ? (cur_s + a_s - mx_s) : (cur_s + a_s);
            end
            OP_BACK_UP: begin
                span   = a_s;
                negate = 1'b1;
                nxt    = (cur_s > a_s) ? (cur_s - a_s) : (mx_s + cur_s - a_s);
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign prod = span * i_cfg.steps_per_cup;

    always_comb begin
        o_plan.step_count = negate ? 24'(-prod) : prod[23:0];
        o_plan.next_cup   = nxt[6:0];
        o_plan.update     = known && i_cmd.motion_ok;
        o_plan.failed     = known && !i_cmd.motion_ok;
        if (!known || i_cmd.operation == OP_HOME) begin
            o_plan.curve_code = CURVE_DEBUG;
        end else begin
            o_plan.curve_code = pick_curve(span, spc_zero);
        end
    end

endmodule

>>> rtl/rotary_plate_index_planner.sv
// Rotary plate index planner.
// A command item enters on i_cmd (operation, cup_arg, motion_ok) and one result
// item leaves on o_res (step_count, curve_code, cup_index, failed) for every
// command. Both channels use a valid/ready handshake; an item moves at a rising
// edge with valid and ready both high.
// The block has two register stages: a command register and a result register.
// A command is held in the command register; its result is then loaded into the
// result register, from which it leaves on o_res. One command per cycle is
// sustained while the output is not stalled; the rate is set by the single pass
// through the planning logic, whose longest path is the 10 x 16 bit step
// multiply.
// The stored cup index is updated as the command leaves the command register,
// so the following command already sees the new index.
// When the receiver holds o_res.ready low, the result register keeps its item,
// the command register fills, and then i_cmd.ready falls until space opens.
// Reset (synchronous, active low) empties both stages, clears the cup index to
// zero and loads steps_per_cup = 0, max_cup = 120, home_cup = 1. APB writes go
// to byte addresses 0, 4, 8; the user must write only while idle (unenforced).
module rotary_plate_index_planner
    import rpip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpip_cmd_if.sink    i_cmd,
    rpip_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       cfg;
    t_plan      plan;

    // Command stage.
    logic       r_in_vld;
    t_cmd       r_cmd;
    // Result stage.
    logic               r_out_vld;
    logic signed [23:0] r_step_count;
    logic [2:0]         r_curve_code;
    logic [6:0]         r_cup_index;
    logic               r_failed;
    // Tracked cup position.
    logic [6:0] r_cur;
    logic [6:0] n_cur;

    logic       adv;
    logic       take;

    rpip_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpip_plan u_plan (
        .i_cmd  (r_cmd),
        .i_cur  (r_cur),
        .i_cfg  (cfg),
        .o_plan (plan)
    );

    // The command stage moves on whenever the result register is empty or drains.
    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || adv;
    assign take        = i_cmd.valid && i_cmd.ready;
    assign n_cur       = (adv && plan.update) ? plan.next_cup : r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cur     <= 7'd0;
        end else begin
            r_cur <= n_cur;
            if (take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.operation <= i_cmd.operation;
            r_cmd.cup_arg   <= i_cmd.cup_arg;
            r_cmd.motion_ok <= i_cmd.motion_ok;
        end
        if (adv) begin
            r_step_count <= plan.step_count;
            r_curve_code <= plan.curve_code;
            r_cup_index  <= n_cur;
            r_failed     <= plan.failed;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.step_count = r_step_count;
    assign o_res.curve_code = r_curve_code;
    assign o_res.cup_index  = r_cup_index;
    assign o_res.failed     = r_failed;

    // A failed or unknown command never moves the tracked cup.
    a_keep_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_cmd.motion_ok |=> $stable(r_cur))
        else $error("cup index changed on a failed command");

    // A successful home lands on the configured home cup.
    a_home_cup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_cmd.motion_ok && r_cmd.operation == OP_HOME
        |=> r_cur == $past(cfg.home_cup))
        else $error("home did not load the home cup");

    // Input back-pressure only when both stages hold an item and the output stalls.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> r_in_vld && r_out_vld && !o_res.ready)
        else $error("input stalled without a full pipeline");

    // The reported index matches the tracked cup right after a result is loaded.
    a_index_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_res.cup_index == r_cur)
        else $error("reported cup index differs from tracked cup");

endmodule
